// File: design/bcd_pkg.sv
// Shared constants, types and helper functions for the brush canvas box downsampler.
package bcd_pkg;

	// Geometry
	localparam int LARGE_SIDE = 140;
	localparam int SMALL_SIDE = 28;
	localparam int BLOCK_SIDE = 5;
	localparam int BLOCK_AREA = BLOCK_SIDE * BLOCK_SIDE;

	// Widths
	localparam int X_W    = (LARGE_SIDE > 1) ? $clog2(LARGE_SIDE) : 1;
	localparam int CR_W   = (SMALL_SIDE > 1) ? $clog2(SMALL_SIDE) : 1;
	localparam int SUM_W  = 5;
	localparam int LVL_W  = 8;
	localparam int RAD_W  = 4;
	localparam int FUNC_W = 2;
	localparam int PTR_W  = 9;
	localparam int CELL_W = 5;
	localparam int OFS_W  = RAD_W + 1;
	localparam int POS_W  = PTR_W + 1;
	localparam int CNT_ROW_W = SMALL_SIDE * SUM_W;

	localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(4);

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_STAMP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW_RD,
		ST_ROW_CELL,
		ST_ROW_WR,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

	// Divide by the block side: reciprocal multiply plus one correction step
	localparam int DIV_SH    = 16;
	localparam int DIV_RECIP = (1 << DIV_SH) / BLOCK_SIDE;

	function automatic logic [X_W-1:0] div_block(input logic [X_W-1:0] v);
		logic [X_W+DIV_SH-1:0] prod;
		logic [X_W-1:0]        q;
		logic [X_W-1:0]        rem;
		prod = (X_W+DIV_SH)'(v) * (X_W+DIV_SH)'(DIV_RECIP);
		q    = X_W'(prod >> DIV_SH);
		rem  = v - X_W'(q * X_W'(BLOCK_SIDE));
		if (rem >= X_W'(BLOCK_SIDE)) begin
			q = q + X_W'(1);
		end
		return q;
	endfunction

	// Level table: floor(sum * 255 / block area)
	typedef logic [LVL_W-1:0] level_lut_t [0:(1<<SUM_W)-1];

	function automatic level_lut_t build_level_lut();
		level_lut_t lut;
		for (int i = 0; i < (1 << SUM_W); i++) begin
			lut[i] = LVL_W'((i * 255) / BLOCK_AREA);
		end
		return lut;
	endfunction

	localparam level_lut_t LEVEL_LUT = build_level_lut();

endpackage

// File: design/bcd_vram.sv
// Row-wide RAM with registered read and per-row valid flags, so clear resets every row together.
module bcd_vram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_word_q;
	logic             rd_valid_q;

	// Storage array, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// Row valid flags: a row never written since clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

// File: design/bcd_brush_unit.sv
// Shared brush test: offset inside the circle and column on the canvas.
module bcd_brush_unit (
	input  logic signed [bcd_pkg::OFS_W-1:0] dx,
	input  logic signed [bcd_pkg::OFS_W-1:0] dy,
	input  logic        [bcd_pkg::RAD_W-1:0] radius,
	input  logic signed [bcd_pkg::POS_W-1:0] x,
	output logic                             hit
);
	import bcd_pkg::*;

	localparam int SQ_W = 2 * OFS_W;

	logic signed [SQ_W-1:0] dx_sq;
	logic signed [SQ_W-1:0] dy_sq;
	logic        [SQ_W:0]   dist_sq;
	logic        [SQ_W:0]   rad_sq;
	logic                   x_on;

	// Squared distance against squared radius
	always_comb begin
		dx_sq   = SQ_W'(dx) * SQ_W'(dx);
		dy_sq   = SQ_W'(dy) * SQ_W'(dy);
		dist_sq = (SQ_W+1)'(unsigned'(dx_sq)) + (SQ_W+1)'(unsigned'(dy_sq));
		rad_sq  = (SQ_W+1)'(radius) * (SQ_W+1)'(radius);
		x_on    = !x[POS_W-1] && (x[POS_W-2:0] < (POS_W-1)'(LARGE_SIDE));
		hit     = (dist_sq < rad_sq) && x_on;
	end

endmodule

// File: design/brush_canvas_box_downsampler.sv
// Top level: sequencer, canvas and block count RAMs, result register.
//
// Input channel (in_valid/in_stall) carries one word per operation: func selects
// clear, stamp or read; pointer_x/pointer_y place the brush; cell_row/cell_col pick
// the downscaled cell. Output channel (out_valid/out_stall) returns one word per
// input word: block_sum and level, zero for anything but an in-range read.
// brush_radius is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. The block
// works on one word at a time and holds in_stall high meanwhile. A stamp walks
// the brush rows in order: for each row on the canvas it reads the canvas row and
// its block count row, the brush test unit checks one cell per cycle across the
// row, and the merged row and updated counts are written back; rows off the
// canvas are skipped.
// Canvas rows and block count rows carry valid flags, so reset and clear take
// effect at once; there is no clearing pass.
// A result waits in the output register while out_stall is high; the next word
// is taken only after the result has moved into that register.
module brush_canvas_box_downsampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcd_pkg::RAD_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bcd_pkg::FUNC_W-1:0]    func,
	input  logic signed [bcd_pkg::PTR_W-1:0] pointer_x,
	input  logic signed [bcd_pkg::PTR_W-1:0] pointer_y,
	input  logic [bcd_pkg::CELL_W-1:0]    cell_row,
	input  logic [bcd_pkg::CELL_W-1:0]    cell_col,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bcd_pkg::SUM_W-1:0]     block_sum,
	output logic [bcd_pkg::LVL_W-1:0]     level
);
	import bcd_pkg::*;

	state_t state_q, state_d;

	logic [RAD_W-1:0]        radius_q;
	logic signed [PTR_W-1:0] px_q, py_q;
	logic signed [OFS_W-1:0] dx_q, dy_q;
	logic signed [OFS_W-1:0] r_s, neg_r;
	logic [LARGE_SIDE-1:0]   mask_q;
	logic [X_W-1:0]          br_q, yrow_q;
	logic                    grid_q;
	logic [CR_W-1:0]         col_q;
	logic                    hit_q;
	logic [SUM_W-1:0]        res_sum_q;
	logic                    out_valid_q;
	logic [SUM_W-1:0]        block_sum_q;
	logic [LVL_W-1:0]        level_q;

	logic                    accept;
	logic                    row_ok, col_ok;
	logic signed [POS_W-1:0] y_cur, x_cur;
	logic                    y_on;
	logic [X_W-1:0]          y_idx, x_idx, br;
	logic                    br_in;
	logic                    dy_last, dx_last;
	logic                    cell_hit;
	logic                    out_load;
	logic                    clear_all;

	logic                    cv_rd_en, cv_wr_en;
	logic [LARGE_SIDE-1:0]   cv_rd_data, cv_wr_data;
	logic                    cnt_rd_en, cnt_wr_en;
	logic [CR_W-1:0]         cnt_rd_addr;
	logic [CNT_ROW_W-1:0]    cnt_rd_data, cnt_wr_data;
	logic [LARGE_SIDE-1:0]   added;

	// Offsets and positions
	always_comb begin
		r_s     = OFS_W'(radius_q);
		neg_r   = -r_s;
		dy_last = (dy_q == r_s);
		dx_last = (dx_q == r_s);
		y_cur   = {py_q[PTR_W-1], py_q} + {{(POS_W-OFS_W){dy_q[OFS_W-1]}}, dy_q};
		x_cur   = {px_q[PTR_W-1], px_q} + {{(POS_W-OFS_W){dx_q[OFS_W-1]}}, dx_q};
		y_on    = !y_cur[POS_W-1] && (y_cur[POS_W-2:0] < (POS_W-1)'(LARGE_SIDE));
		y_idx   = y_cur[X_W-1:0];
		x_idx   = x_cur[X_W-1:0];
		br      = div_block(y_idx);
		br_in   = (32'(br) < 32'(SMALL_SIDE));
		row_ok  = (32'(cell_row) < 32'(SMALL_SIDE));
		col_ok  = (32'(cell_col) < 32'(SMALL_SIDE));
		accept  = in_valid && !in_stall;
		out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// Shared brush test unit
	bcd_brush_unit u_brush (
		.dx     (dx_q),
		.dy     (dy_q),
		.radius (radius_q),
		.x      (x_cur),
		.hit    (cell_hit)
	);

	// Canvas rows, one bit per cell
	bcd_vram #(.WIDTH(LARGE_SIDE), .DEPTH(LARGE_SIDE)) u_canvas (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear_all),
		.rd_en   (cv_rd_en),
		.rd_addr (y_idx),
		.rd_data (cv_rd_data),
		.wr_en   (cv_wr_en),
		.wr_addr (yrow_q),
		.wr_data (cv_wr_data)
	);

	// Block count rows, one count per downscaled cell
	bcd_vram #(.WIDTH(CNT_ROW_W), .DEPTH(SMALL_SIDE)) u_counts (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear_all),
		.rd_en   (cnt_rd_en),
		.rd_addr (cnt_rd_addr),
		.rd_data (cnt_rd_data),
		.wr_en   (cnt_wr_en),
		.wr_addr (CR_W'(br_q)),
		.wr_data (cnt_wr_data)
	);

	// Row write-back: merge brush mask, add newly set cells to each block count
	always_comb begin
		logic [SUM_W-1:0] acc;
		cv_wr_data  = cv_rd_data | mask_q;
		added       = mask_q & ~cv_rd_data;
		cnt_wr_data = '0;
		for (int bc = 0; bc < SMALL_SIDE; bc++) begin
			acc = cnt_rd_data[bc*SUM_W +: SUM_W];
			for (int k = 0; k < BLOCK_SIDE; k++) begin
				if (bc * BLOCK_SIDE + k < LARGE_SIDE) begin
					acc = acc + SUM_W'(added[bc*BLOCK_SIDE + k]);
				end
			end
			cnt_wr_data[bc*SUM_W +: SUM_W] = acc;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM controls
	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		clear_all   = 1'b0;
		cv_rd_en    = 1'b0;
		cv_wr_en    = 1'b0;
		cnt_rd_en   = 1'b0;
		cnt_wr_en   = 1'b0;
		cnt_rd_addr = CR_W'(br);
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cnt_rd_addr = CR_W'(cell_row);
				if (in_valid) begin
					case (func)
						FUNC_CLEAR: begin
							clear_all = 1'b1;
							state_d   = ST_DONE;
						end
						FUNC_STAMP: state_d = ST_ROW_RD;
						FUNC_READ: begin
							cnt_rd_en = row_ok && col_ok;
							state_d   = ST_READ_WAIT;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_ROW_RD: begin
				if (y_on) begin
					cv_rd_en  = 1'b1;
					cnt_rd_en = br_in;
					state_d   = ST_ROW_CELL;
				end else if (dy_last) begin
					state_d = ST_DONE;
				end
			end
			ST_ROW_CELL: begin
				if (dx_last) begin
					state_d = ST_ROW_WR;
				end
			end
			ST_ROW_WR: begin
				cv_wr_en  = 1'b1;
				cnt_wr_en = grid_q;
				state_d   = dy_last ? ST_DONE : ST_ROW_RD;
			end
			ST_READ_WAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Brush radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					px_q      <= pointer_x;
					py_q      <= pointer_y;
					dy_q      <= neg_r;
					col_q     <= CR_W'(cell_col);
					hit_q     <= row_ok && col_ok;
					res_sum_q <= '0;
				end
			end
			ST_ROW_RD: begin
				mask_q <= '0;
				dx_q   <= neg_r;
				br_q   <= br;
				yrow_q <= y_idx;
				grid_q <= br_in;
				if (!y_on) begin
					dy_q <= dy_q + OFS_W'(1);
				end
			end
			ST_ROW_CELL: begin
				if (cell_hit) begin
					mask_q[x_idx] <= 1'b1;
				end
				dx_q <= dx_q + OFS_W'(1);
			end
			ST_ROW_WR: dy_q <= dy_q + OFS_W'(1);
			ST_READ_WAIT: begin
				res_sum_q <= hit_q ? cnt_rd_data[col_q*SUM_W +: SUM_W] : '0;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			block_sum_q <= res_sum_q;
			level_q     <= LEVEL_LUT[res_sum_q];
		end
	end

	assign out_valid = out_valid_q;
	assign block_sum = block_sum_q;
	assign level     = level_q;

endmodule

// File: verif/brush_canvas_box_downsampler_test.sv
// Self-checking testbench for the brush canvas box downsampler: random words, modeled results.
`timescale 1ns / 100ps

module brush_canvas_box_downsampler_test;
	import bcd_pkg::*;

	// func code with no operation behind it
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// cycles with no handshake on either channel before the run is declared hung
	localparam int HANG_LIMIT = 20000;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [PTR_W-1:0]  px;
		logic [PTR_W-1:0]  py;
		logic [CELL_W-1:0] row;
		logic [CELL_W-1:0] col;
	} op_word_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [LVL_W-1:0] lvl;
	} blk_result_t;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    cfg_we     = 1'b0;
	logic [RAD_W-1:0]        cfg_wdata  = '0;
	logic                    in_valid   = 1'b0;
	logic                    in_stall;
	logic [FUNC_W-1:0]       func       = FUNC_CLEAR;
	logic signed [PTR_W-1:0] pointer_x  = '0;
	logic signed [PTR_W-1:0] pointer_y  = '0;
	logic [CELL_W-1:0]       cell_row   = '0;
	logic [CELL_W-1:0]       cell_col   = '0;
	logic                    out_valid;
	logic                    out_stall  = 1'b0;
	logic [SUM_W-1:0]        block_sum;
	logic [LVL_W-1:0]        level;

	// pending words for the driver, expected results in order
	op_word_t    word_q[$];
	blk_result_t result_q[$];

	// shadow canvas, block counts and brush radius
	bit [LARGE_SIDE-1:0] canvas_row [LARGE_SIDE];
	int                  blk_cnt [SMALL_SIDE][SMALL_SIDE];
	int                  radius_now = int'(RADIUS_RST);

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  mismatches     = 0;
	int  sent_cnt       = 0;
	int  hang_cnt       = 0;
	int  aim_x          = 70;
	int  aim_y          = 70;
	bit  word_taken     = 1'b0;
	bit  drain_hold     = 1'b0;

	brush_canvas_box_downsampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.pointer_x (pointer_x),
		.pointer_y (pointer_y),
		.cell_row  (cell_row),
		.cell_col  (cell_col),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.block_sum (block_sum),
		.level     (level)
	);

	initial forever #4 clk = ~clk;

	// Apply one word to the shadow canvas and return the block readout it produces
	function automatic blk_result_t paint_and_read(input op_word_t w);
		blk_result_t r;
		int          x, y, dx, dy, rad, s;
		r   = '0;
		rad = radius_now;
		case (w.func)
			FUNC_CLEAR: begin
				for (int i = 0; i < LARGE_SIDE; i++) canvas_row[i] = '0;
				for (int i = 0; i < SMALL_SIDE; i++)
					for (int j = 0; j < SMALL_SIDE; j++) blk_cnt[i][j] = 0;
			end
			FUNC_STAMP: begin
				for (dy = -rad; dy <= rad; dy++) begin
					for (dx = -rad; dx <= rad; dx++) begin
						x = $signed(w.px) + dx;
						y = $signed(w.py) + dy;
						// inside the disc, on the canvas, and not already set
						if (dx * dx + dy * dy < rad * rad && x >= 0 && x < LARGE_SIDE &&
								y >= 0 && y < LARGE_SIDE && !canvas_row[y][x]) begin
							canvas_row[y][x] = 1'b1;
							if (y / BLOCK_SIDE < SMALL_SIDE && x / BLOCK_SIDE < SMALL_SIDE)
								blk_cnt[y / BLOCK_SIDE][x / BLOCK_SIDE]++;
						end
					end
				end
			end
			FUNC_READ: begin
				if (w.row < SMALL_SIDE && w.col < SMALL_SIDE) begin
					s     = blk_cnt[w.row][w.col];
					r.sum = SUM_W'(s);
					r.lvl = LVL_W'(s * 255 / BLOCK_AREA);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Build a word: stamps and reads cluster around the last stamp so blocks fill up
	function automatic op_word_t random_word();
		op_word_t w;
		int       pick, v;
		pick  = $urandom_range(99);
		w.px  = PTR_W'($urandom);
		w.py  = PTR_W'($urandom);
		w.row = CELL_W'($urandom);
		w.col = CELL_W'($urandom);
		if (pick < 3)
			w.func = FUNC_CLEAR;
		else if (pick < 45)
			w.func = FUNC_STAMP;
		else if (pick < 93)
			w.func = FUNC_READ;
		else
			w.func = FUNC_UNUSED;
		if (w.func == FUNC_STAMP && $urandom_range(9) != 0) begin
			if ($urandom_range(1)) begin
				w.px = PTR_W'(aim_x + int'($urandom_range(12)) - 6);
				w.py = PTR_W'(aim_y + int'($urandom_range(12)) - 6);
			end else begin
				w.px = PTR_W'(int'($urandom_range(159)) - 10);
				w.py = PTR_W'(int'($urandom_range(159)) - 10);
			end
			v = $signed(w.px);
			if (v >= 0 && v < LARGE_SIDE) aim_x = v;
			v = $signed(w.py);
			if (v >= 0 && v < LARGE_SIDE) aim_y = v;
		end
		if (w.func == FUNC_READ && $urandom_range(9) != 0) begin
			if ($urandom_range(1)) begin
				v = aim_y + int'($urandom_range(8)) - 4;
				w.row = CELL_W'((v < 0 ? 0 : (v >= LARGE_SIDE ? LARGE_SIDE - 1 : v)) / BLOCK_SIDE);
				v = aim_x + int'($urandom_range(8)) - 4;
				w.col = CELL_W'((v < 0 ? 0 : (v >= LARGE_SIDE ? LARGE_SIDE - 1 : v)) / BLOCK_SIDE);
			end else begin
				w.row = CELL_W'($urandom_range(SMALL_SIDE - 1));
				w.col = CELL_W'($urandom_range(SMALL_SIDE - 1));
			end
		end
		return w;
	endfunction

	task automatic queue_word(input logic [FUNC_W-1:0] f, input int px, input int py,
			input int row, input int col);
		op_word_t w;
		w.func = f;
		w.px   = PTR_W'(px);
		w.py   = PTR_W'(py);
		w.row  = CELL_W'(row);
		w.col  = CELL_W'(col);
		word_q = {word_q, w};
	endtask

	// Block is idle once nothing is queued, in flight or owed
	task automatic wait_idle();
		while (word_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radius(input int rad);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= RAD_W'(rad);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Word driver and output stall, changed at the falling edge
	always @(negedge clk) begin
		op_word_t w;
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (!in_valid || word_taken) begin
				if (drain_hold && result_q.size() != 0) begin
					in_valid <= 1'b0;
				end else if (word_q.size() == 0 || $urandom_range(99) < send_idle_pct) begin
					in_valid <= 1'b0;
				end else begin
					w = word_q.pop_front();
					func      <= w.func;
					pointer_x <= w.px;
					pointer_y <= w.py;
					cell_row  <= w.row;
					cell_col  <= w.col;
					in_valid  <= 1'b1;
					sent_cnt++;
					// now and then let every result drain before the next word
					drain_hold = (sent_cnt % 61 == 0);
				end
			end
		end
	end

	// Checker: compare results, then model any word accepted this edge
	always @(posedge clk) begin
		op_word_t    w;
		blk_result_t want;
		word_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_we) radius_now = int'(cfg_wdata);
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("unexpected result: block_sum=%0d level=%0d", block_sum, level);
					mismatches++;
				end else begin
					want = result_q.pop_front();
					if (block_sum !== want.sum) begin
						$error("block_sum mismatch: expected %0d, actual %0d", want.sum, block_sum);
						mismatches++;
					end
					if (level !== want.lvl) begin
						$error("level mismatch: expected %0d, actual %0d", want.lvl, level);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				w.func = func;
				w.px   = pointer_x;
				w.py   = pointer_y;
				w.row  = cell_row;
				w.col  = cell_col;
				result_q = {result_q, paint_and_read(w)};
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				hang_cnt <= 0;
			else
				hang_cnt <= hang_cnt + 1;
			if (hang_cnt >= HANG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int rad, n;
		for (int i = 0; i < LARGE_SIDE; i++) canvas_row[i] = '0;
		for (int i = 0; i < SMALL_SIDE; i++)
			for (int j = 0; j < SMALL_SIDE; j++) blk_cnt[i][j] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin rad = 4;  send_idle_pct = 0;  recv_stall_pct = 0;  n = 150; end
				1: begin rad = 15; send_idle_pct = 60; recv_stall_pct = 0;  n = 140; end
				2: begin rad = 0;  send_idle_pct = 0;  recv_stall_pct = 60; n = 120; end
				3: begin rad = 1;  send_idle_pct = 18; recv_stall_pct = 18; n = 150; end
				4: begin
					rad = $urandom_range(14, 2);
					send_idle_pct = 0;
					recv_stall_pct = 0;
					n = 140;
				end
				default: begin rad = 7; send_idle_pct = 18; recv_stall_pct = 18; n = 150; end
			endcase
			write_radius(rad);

			if (ph == 0) begin
				// empty canvas, corner stamps clipped on two sides
				queue_word(FUNC_READ, 0, 0, 0, 0);
				queue_word(FUNC_STAMP, 2, 2, 0, 0);
				queue_word(FUNC_READ, 0, 0, 0, 0);
				queue_word(FUNC_READ, 0, 0, 0, 1);
				queue_word(FUNC_READ, 0, 0, 1, 1);
				queue_word(FUNC_STAMP, 139, 139, 31, 31);
				queue_word(FUNC_READ, -1, -1, 27, 27);
				// pointers far off canvas stamp nothing
				queue_word(FUNC_STAMP, -256, -256, 0, 0);
				queue_word(FUNC_STAMP, 255, 255, 0, 0);
				queue_word(FUNC_STAMP, 255, -256, 0, 0);
				// brush centered off the left edge, only a sliver lands
				queue_word(FUNC_STAMP, -3, 70, 0, 0);
				queue_word(FUNC_READ, 0, 0, 14, 0);
				// a full block reads 25 / 255
				queue_word(FUNC_STAMP, 72, 72, 0, 0);
				queue_word(FUNC_READ, 0, 0, 14, 14);
				// unused func leaves the canvas alone
				queue_word(FUNC_UNUSED, -1, -1, 31, 31);
				queue_word(FUNC_READ, 0, 0, 14, 14);
				// reads outside the downscaled grid
				queue_word(FUNC_READ, 0, 0, 28, 0);
				queue_word(FUNC_READ, 0, 0, 0, 28);
				queue_word(FUNC_READ, 0, 0, 31, 31);
				queue_word(FUNC_STAMP, 0, 139, 0, 0);
				queue_word(FUNC_READ, 0, 0, 27, 0);
				// clear, then restamp the same spot twice
				queue_word(FUNC_CLEAR, -256, 255, 31, 31);
				queue_word(FUNC_READ, 0, 0, 14, 14);
				queue_word(FUNC_STAMP, 72, 72, 0, 0);
				queue_word(FUNC_STAMP, 72, 72, 0, 0);
				queue_word(FUNC_READ, 0, 0, 14, 14);
			end
			for (int i = 0; i < n; i++) word_q = {word_q, random_word()};
		end

		wait_idle();
		// room for a stray extra result from a slow stamp
		repeat (1100) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
design/bcd_pkg.sv
design/bcd_vram.sv
design/bcd_brush_unit.sv
design/brush_canvas_box_downsampler.sv
verif/brush_canvas_box_downsampler_test.sv
